@@ sv/mkte_pkg.sv @@
`default_nettype none

package mkte_pkg;

	// Reset value of the repeat timeout
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// Offset between lower and upper case ASCII letters
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// Marks a key code that belongs to no key
	localparam logic [3:0] SLOT_NONE = 4'd15;

	typedef enum logic [1:0] {
		CMD_PRESS     = 2'd0,
		CMD_BACKSPACE = 2'd1,
		CMD_TOGGLE    = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_APPENDED = 3'd1,
		ST_REPLACED = 3'd2,
		ST_DELETED  = 3'd3,
		ST_FULL     = 3'd4,
		ST_TOGGLED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  key_code;
		logic [7:0]  field_id;
		logic [31:0] time_ms;
		logic [15:0] text_length;
		logic [15:0] buffer_capacity;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_char;
		logic [15:0] position;
		logic        uppercase_now;
	} out_t;

	typedef struct packed {
		logic        cycle_active;
		logic [7:0]  active_key;
		logic [1:0]  cycle_index;
		logic [15:0] edit_position;
		logic [31:0] last_press_ms;
		logic [7:0]  current_field;
		logic        uppercase_mode;
	} state_t;

	// Map a key code to its slot in the letter table
	function automatic logic [3:0] key_slot(input logic [7:0] k);
		logic [3:0] s;
		if (k >= "1" && k <= "9") begin
			s = 4'(k - "1");
		end else if (k == "0") begin
			s = 4'd9;
		end else if (k == "*") begin
			s = 4'd10;
		end else begin
			s = SLOT_NONE;
		end
		return s;
	endfunction

	// Number of letters on a key
	function automatic logic [2:0] seq_len(input logic [3:0] slot);
		logic [2:0] n;
		case (slot)
			4'd0:    n = 3'd1;
			4'd6:    n = 3'd4;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			4'd10:   n = 3'd4;
			default: n = 3'd3;
		endcase
		return n;
	endfunction

	// Letter at a given cycle index of a key, zero past the end
	function automatic logic [7:0] seq_char(input logic [3:0] slot, input logic [1:0] idx);
		logic [31:0] row;
		case (slot)
			4'd0:    row = {"1", 24'd0};
			4'd1:    row = {"abc", 8'd0};
			4'd2:    row = {"def", 8'd0};
			4'd3:    row = {"ghi", 8'd0};
			4'd4:    row = {"jkl", 8'd0};
			4'd5:    row = {"mno", 8'd0};
			4'd6:    row = "pqrs";
			4'd7:    row = {"tuv", 8'd0};
			4'd8:    row = "wxyz";
			4'd9:    row = {" 0", 16'd0};
			4'd10:   row = ".,!?";
			default: row = 32'd0;
		endcase
		return row[(2'd3 - idx) * 8 +: 8];
	endfunction

endpackage

`default_nettype wire

@@ sv/mkte_decode.sv @@
`default_nettype none

module mkte_decode (
	input  wire mkte_pkg::state_t state,
	input  wire mkte_pkg::in_t    item,
	input  wire [15:0]            timeout,
	output mkte_pkg::out_t        result,
	output mkte_pkg::state_t      next_state
);
	import mkte_pkg::*;

	logic [3:0]  slot;
	logic [2:0]  n;
	logic [31:0] gap;
	logic [2:0]  idx_inc;
	logic [1:0]  idx_next;
	logic [7:0]  raw_char;
	logic [15:0] len_m1;
	logic        is_repeat;
	logic        full;
	logic        done;
	state_t      st;
	state_t      cleared;
	status_t     status;
	logic [7:0]  ch;
	logic [15:0] pos;

	// Derive key slot, letter count, length minus one and the full flag
	always_comb begin
		slot     = key_slot(item.key_code);
		n        = seq_len(slot);
		len_m1   = item.text_length - 16'd1;
		full     = ({1'b0, item.text_length} + 17'd1) >= {1'b0, item.buffer_capacity};
	end

	// Sequence the event against the current state
	always_comb begin
		cleared                = state;
		cleared.cycle_active   = 1'b0;
		cleared.active_key     = '0;
		cleared.cycle_index    = '0;
		cleared.edit_position  = '0;
		cleared.last_press_ms  = '0;

		st        = state;
		status    = ST_IGNORED;
		ch        = '0;
		pos       = '0;
		gap       = '0;
		idx_inc   = '0;
		idx_next  = '0;
		raw_char  = '0;
		is_repeat = 1'b0;
		done      = 1'b0;

		case (item.command)
			CMD_PRESS: begin
				if (item.buffer_capacity == 16'd0) begin
					status = ST_FULL;
				end else if (slot != SLOT_NONE) begin
					// Adopt a new field with a fresh cycle
					if (state.current_field != item.field_id) begin
						st               = cleared;
						st.current_field = item.field_id;
					end
					gap       = item.time_ms - st.last_press_ms;
					is_repeat = st.cycle_active && st.active_key == item.key_code
						&& gap <= {16'd0, timeout};
					if (is_repeat) begin
						idx_inc        = {1'b0, st.cycle_index} + 3'd1;
						idx_next       = (idx_inc >= n) ? 2'd0 : idx_inc[1:0];
						st.cycle_index = idx_next;
						if (st.edit_position < item.text_length) begin
							raw_char         = seq_char(slot, idx_next);
							pos              = st.edit_position;
							st.last_press_ms = item.time_ms;
							status           = ST_REPLACED;
							done             = 1'b1;
						end
					end
					if (!done) begin
						if (full) begin
							status = ST_FULL;
						end else begin
							raw_char         = seq_char(slot, 2'd0);
							pos              = item.text_length;
							st.cycle_active  = 1'b1;
							st.active_key    = item.key_code;
							st.cycle_index   = '0;
							st.edit_position = item.text_length;
							st.last_press_ms = item.time_ms;
							status           = ST_APPENDED;
						end
					end
					// Apply the case flag to letters
					if (status == ST_APPENDED || status == ST_REPLACED) begin
						if (st.uppercase_mode && raw_char >= "a" && raw_char <= "z") begin
							ch = raw_char - CASE_OFFSET;
						end else begin
							ch = raw_char;
						end
					end
				end
			end
			CMD_BACKSPACE: begin
				if (item.text_length == 16'd0) begin
					st = cleared;
				end else begin
					status = ST_DELETED;
					pos    = len_m1;
					if (state.cycle_active && state.current_field == item.field_id
						&& state.edit_position >= len_m1) begin
						st = cleared;
					end
				end
			end
			CMD_TOGGLE: begin
				st                = cleared;
				st.uppercase_mode = !state.uppercase_mode;
				status            = ST_TOGGLED;
			end
			default: begin
				st = state;
			end
		endcase

		next_state           = st;
		result.status        = status;
		result.out_char      = ch;
		result.position      = pos;
		result.uppercase_now = st.uppercase_mode;
	end

endmodule

`default_nettype wire

@@ sv/multitap_keypad_text_entry_unit.sv @@
// Multi-tap phone keypad decoder.
// Input channel (in_valid/in_ready/in_data) carries one key press, backspace
// or case toggle per request, with field id, timestamp and the host buffer's
// length and capacity. Output channel (out_valid/out_ready/out_data) returns
// exactly one edit command per request: ignored, append, replace, delete,
// full or case toggled, plus the case flag after the event.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the repeat
// timeout in ms; it is always ready and should be written only while idle.
// A request accepted into the input register is decoded into the output
// register once that register is free or drains; one request per cycle
// when not stalled. The decode reads the edit state written by the previous
// request in the same cycle it moves to the output register.
// Receiver stall: the output register holds its result; the input register
// keeps one more request, then in_ready drops until out_ready returns.
// Reset: empty pipeline, cleared edit state, lower case, timeout 1000 ms.
`default_nettype none

module multitap_keypad_text_entry_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire mkte_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output mkte_pkg::out_t      out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [15:0]          cfg_data
);
	import mkte_pkg::*;

	logic        valid_s1;
	in_t         item_s1;
	logic        valid_s2;
	out_t        result_s2;
	state_t      state_q;
	logic [15:0] timeout_q;
	out_t        result;
	state_t      next_state;
	logic        advance;

	// Move stage 1 forward when the output register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	mkte_decode u_decode (
		.state      (state_q),
		.item       (item_s1),
		.timeout    (timeout_q),
		.result     (result),
		.next_state (next_state)
	);

	// Hold the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// Advance pipeline valids and the edit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= next_state;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

`default_nettype wire

@@ sv/mkte_checker.sv @@
`default_nettype none

module mkte_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire mkte_pkg::out_t out_data
);
	import mkte_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// Drive a character only for append and replace
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_APPENDED && out_data.status != ST_REPLACED
		|-> out_data.out_char == 8'd0)
		else $error("character on a command without one");

	// Drive a position only for append, replace and delete
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_IGNORED || out_data.status == ST_FULL
		|| out_data.status == ST_TOGGLED) |-> out_data.position == 16'd0)
		else $error("position on a command without one");

	// Keep the input open while the output register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule

bind multitap_keypad_text_entry_unit mkte_checker u_mkte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
